@@ hw/rtl/scg_pkg.sv @@
package scg_pkg;

  localparam int unsigned CNT_W = 21;
  localparam int unsigned POS_W = 20;
  localparam logic [CNT_W-1:0] MAX_ROWS = 21'd1048576;
  localparam logic [CNT_W-1:0] MAX_COLS = 21'd1048576;

  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

  // configuration register indexes
  localparam logic [1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [1:0] REG_COL_COUNT = 2'd1;
  localparam logic [1:0] REG_PER_ROW   = 2'd2;
  localparam logic [1:0] REG_SEED      = 2'd3;

  // classified request, front to back
  typedef struct packed {
    logic             past_end;
    logic [CNT_W-1:0] row;
    logic             last_in_row;
    logic             last_entry;
    logic [63:0]      state;
    logic [CNT_W-1:0] cols;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } back_state_t;

  // zero acts as one, large values saturate
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] r;
    r = (v == '0) ? CNT_W'(1) : v;
    if (r > lim) r = lim;
    return r;
  endfunction

endpackage

@@ hw/rtl/scg_front.sv @@
module scg_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req,
  input  logic                       restart,
  input  logic [scg_pkg::CNT_W-1:0]  row_count,
  input  logic [scg_pkg::CNT_W-1:0]  col_count,
  input  logic [scg_pkg::CNT_W-1:0]  entries_per_row,
  input  logic [63:0]                seed,
  output scg_pkg::item_t             item
);

  logic [63:0]               gen_r, gen_nxt;
  logic [scg_pkg::POS_W-1:0] row_r, row_nxt;
  logic [scg_pkg::POS_W-1:0] ent_r, ent_nxt;
  logic                      fin_r, fin_nxt;

  logic [scg_pkg::CNT_W-1:0] rows, cols, per_row;
  logic [63:0]               gen_cur, gen_adv;
  logic [scg_pkg::POS_W-1:0] row_cur, ent_cur;
  logic                      fin_cur, done, eor, eom;

  // classify the request against live counts
  always_comb begin
    rows    = scg_pkg::clamp_count(row_count, scg_pkg::MAX_ROWS);
    cols    = scg_pkg::clamp_count(col_count, scg_pkg::MAX_COLS);
    per_row = scg_pkg::clamp_count(entries_per_row, scg_pkg::MAX_COLS);
    if (per_row > cols) per_row = cols;
    gen_cur = restart ? ((seed != 64'd0) ? seed : 64'd1) : gen_r;
    row_cur = restart ? '0 : row_r;
    ent_cur = restart ? '0 : ent_r;
    fin_cur = restart ? 1'b0 : fin_r;
    done    = fin_cur || ({1'b0, row_cur} >= rows);
    gen_adv = gen_cur + scg_pkg::GOLDEN_STEP;
    eor     = ({1'b0, ent_cur} + 21'd1) >= per_row;
    eom     = eor && (({1'b0, row_cur} + 21'd1) >= rows);

    item.past_end    = done;
    item.row         = done ? '0 : ({1'b0, row_cur} + 21'd1);
    item.last_in_row = !done && eor;
    item.last_entry  = !done && eom;
    item.state       = gen_adv;
    item.cols        = cols;

    gen_nxt = gen_cur;
    row_nxt = row_cur;
    ent_nxt = ent_cur;
    fin_nxt = fin_cur;
    if (!done) begin
      gen_nxt = gen_adv;
      if (eom) begin
        fin_nxt = 1'b1;
      end else if (eor) begin
        ent_nxt = '0;
        row_nxt = row_cur + 20'd1;
      end else begin
        ent_nxt = ent_cur + 20'd1;
      end
    end
  end

  // advance on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= 64'd1;
      row_r <= '0;
      ent_r <= '0;
      fin_r <= 1'b0;
    end else if (req) begin
      gen_r <= gen_nxt;
      row_r <= row_nxt;
      ent_r <= ent_nxt;
      fin_r <= fin_nxt;
    end
  end

endmodule

@@ hw/rtl/scg_fifo.sv @@
module scg_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  scg_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output scg_pkg::item_t pop_item,
  output logic [1:0]     count
);

  scg_pkg::item_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_item  = mem_r[rp_r];
  assign count     = cnt_r;

  // hold payload entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  // track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ hw/rtl/scg_back.sv @@
module scg_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  scg_pkg::item_t            q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [scg_pkg::CNT_W-1:0] out_row_number,
  output logic [scg_pkg::CNT_W-1:0] out_column_number,
  output logic                      out_last_in_row,
  output logic                      out_last_entry,
  output logic                      out_past_end
);

  scg_pkg::back_state_t st_r, st_nxt;

  scg_pkg::item_t            it_r;
  logic [63:0]               x_r, acc_r;
  logic [1:0]                mstep_r;
  logic                      pass_r;
  logic [5:0]                cnt_r;
  logic [scg_pkg::POS_W-1:0] rem_r;

  logic                      ov_r;
  logic [scg_pkg::CNT_W-1:0] orow_r, ocol_r;
  logic                      olir_r, olen_r, ope_r;

  logic        load_out, mul_last;
  logic [63:0] cst, term, acc_sum;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [scg_pkg::CNT_W-1:0] rem_sh, rem_sub;

  // one 32x32 multiplier builds the low 64 bits over three steps
  always_comb begin
    cst = pass_r ? scg_pkg::MIX_MUL_B : scg_pkg::MIX_MUL_A;
    ma  = (mstep_r == 2'd2) ? x_r[63:32] : x_r[31:0];
    mb  = (mstep_r == 2'd1) ? cst[63:32] : cst[31:0];
    prod = ma * mb;
    term = (mstep_r == 2'd0) ? prod : {prod[31:0], 32'd0};
    acc_sum = acc_r + term;
    mul_last = (mstep_r == 2'd2);
  end

  // restoring remainder step, one dividend bit per cycle
  always_comb begin
    rem_sh  = {rem_r, x_r[63]};
    rem_sub = (rem_sh >= it_r.cols) ? (rem_sh - it_r.cols) : rem_sh;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      scg_pkg::BK_IDLE: if (q_valid) st_nxt = q_item.past_end ? scg_pkg::BK_DONE
                                                             : scg_pkg::BK_MUL;
      scg_pkg::BK_MUL:  if (mul_last && pass_r) st_nxt = scg_pkg::BK_DIV;
      scg_pkg::BK_DIV:  if (cnt_r == 6'd63) st_nxt = scg_pkg::BK_DONE;
      scg_pkg::BK_DONE: if (!ov_r || !out_stall) st_nxt = scg_pkg::BK_IDLE;
      default:          st_nxt = scg_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    case (st_r)
      scg_pkg::BK_IDLE: q_pop = q_valid;
      scg_pkg::BK_DONE: load_out = !ov_r || !out_stall;
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      scg_pkg::BK_IDLE: begin
        it_r    <= q_item;
        x_r     <= q_item.state ^ (q_item.state >> 30);
        acc_r   <= '0;
        mstep_r <= 2'd0;
        pass_r  <= 1'b0;
        rem_r   <= '0;
      end
      scg_pkg::BK_MUL: begin
        if (mul_last) begin
          acc_r   <= '0;
          mstep_r <= 2'd0;
          pass_r  <= 1'b1;
          cnt_r   <= 6'd0;
          x_r     <= pass_r ? (acc_sum ^ (acc_sum >> 31)) : (acc_sum ^ (acc_sum >> 27));
        end else begin
          acc_r   <= acc_sum;
          mstep_r <= mstep_r + 2'd1;
        end
      end
      scg_pkg::BK_DIV: begin
        rem_r <= rem_sub[scg_pkg::POS_W-1:0];
        x_r   <= {x_r[62:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
      end
      default: ;
    endcase
  end

  // output register, loaded when empty or while the previous result is taken
  always_ff @(posedge clk) begin
    if (load_out) begin
      orow_r <= it_r.row;
      ocol_r <= it_r.past_end ? '0 : ({1'b0, rem_r} + 21'd1);
      olir_r <= it_r.last_in_row;
      olen_r <= it_r.last_entry;
      ope_r  <= it_r.past_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= scg_pkg::BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  assign out_valid         = ov_r;
  assign out_row_number    = orow_r;
  assign out_column_number = ocol_r;
  assign out_last_in_row   = olir_r;
  assign out_last_entry    = olen_r;
  assign out_past_end      = ope_r;

endmodule

@@ hw/rtl/sparse_coordinate_generator_unit.sv @@
// Sparse matrix coordinate generator. Each request transfer yields one result
// with the next row, in row-major order, and a column taken from the mixed
// splitmix64 state, both 1-based; restart reloads the state from seed and
// rewinds. The front stage classifies a request and advances the state in the
// cycle it is taken, so requests enter back to back until the two-entry queue
// fills. The back stage mixes the state with one shared 32x32 multiplier (three
// steps per 64-bit product, two products) and reduces it modulo the column
// count one bit per cycle. Configuration writes are always accepted and apply
// to the next request.
module sparse_coordinate_generator_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_restart,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [scg_pkg::CNT_W-1:0] out_row_number,
  output logic [scg_pkg::CNT_W-1:0] out_column_number,
  output logic                      out_last_in_row,
  output logic                      out_last_entry,
  output logic                      out_past_end,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [63:0]               cfg_data
);

  logic [scg_pkg::CNT_W-1:0] row_count_r, col_count_r, per_row_r;
  logic [63:0]               seed_r;

  scg_pkg::item_t f_item, q_item;
  logic           req, q_full, q_valid, q_pop;
  logic [1:0]     q_count;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign req       = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= 21'd1;
      col_count_r <= 21'd1;
      per_row_r   <= 21'd1;
      seed_r      <= 64'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        scg_pkg::REG_ROW_COUNT: row_count_r <= cfg_data[scg_pkg::CNT_W-1:0];
        scg_pkg::REG_COL_COUNT: col_count_r <= cfg_data[scg_pkg::CNT_W-1:0];
        scg_pkg::REG_PER_ROW:   per_row_r   <= cfg_data[scg_pkg::CNT_W-1:0];
        scg_pkg::REG_SEED:      seed_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  scg_front u_front (
    .clk, .rst_n, .req, .restart(in_restart),
    .row_count(row_count_r), .col_count(col_count_r),
    .entries_per_row(per_row_r), .seed(seed_r), .item(f_item)
  );

  scg_fifo u_fifo (
    .clk, .rst_n, .push(req), .push_item(f_item), .pop(q_pop),
    .full(q_full), .not_empty(q_valid), .pop_item(q_item), .count(q_count)
  );

  scg_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .out_valid, .out_stall, .out_row_number, .out_column_number,
    .out_last_in_row, .out_last_entry, .out_past_end
  );

  // past-end results carry zero coordinates and no flags
  a_past_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_past_end |-> out_row_number == '0 && out_column_number == '0
      && !out_last_in_row && !out_last_entry)
    else $error("past-end result with nonzero fields");

  // a real coordinate lies within the column range
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_past_end |-> out_column_number != '0
      && out_column_number <= scg_pkg::MAX_COLS)
    else $error("column out of range");

  // queue never overfills and stalls the input when full
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count != 2'd3 && (q_count != 2'd2 || in_stall))
    else $error("queue overflow");

endmodule
